@@ sv/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation unit.
// No dependencies; the datapath, controller and top-level files refer to this package by scoped names.
package mexp_pkg;

  localparam int DEFAULT_WIDTH = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_STEP,
    ST_EMIT
  } state_t;

  // Operation run on the shared modular multiplier.
  typedef enum logic [1:0] {
    OP_RED,
    OP_MUL,
    OP_SQR
  } op_t;

  typedef struct packed {
    logic load;
    logic exp_zero;
    logic start;
    logic step;
    logic commit;
    logic emit;
    op_t  op;
  } cmd_t;

endpackage

@@ sv/mexp_in_if.sv @@
// Request channel interface carrying one base value per request.
// Depends on nothing but its width parameter.
interface mexp_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base_value;

  modport source (output valid, output base_value, input ready);
  modport sink (input valid, input base_value, output ready);
endinterface

@@ sv/mexp_out_if.sv @@
// Result channel interface carrying one power result per request.
// Depends on nothing but its width parameter.
interface mexp_out_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

@@ sv/mexp_datapath.sv @@
// Datapath: bit-serial modular multiplier shared by base reduction, multiply
// and square, plus the result and base registers. Uses mexp_pkg.
module mexp_datapath #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] modulus,
  input  logic [WIDTH-1:0] in_base,
  input  mexp_pkg::cmd_t   cmd,
  output logic [WIDTH-1:0] out_data
);

  localparam int EW = WIDTH + 2;

  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] res_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] mplr_r;
  logic [WIDTH-1:0] mcand_r;
  logic [WIDTH-1:0] out_data_r;

  logic [EW-1:0]    m_ext;
  logic [EW-1:0]    m_dbl;
  logic [EW-1:0]    sum;
  logic [WIDTH-1:0] acc_nxt;
  logic [WIDTH-1:0] one_mod;

  // A modulus of zero stands for 2^WIDTH, so reductions become a plain wrap.
  assign m_ext   = (modulus == '0) ? (EW'(1) << WIDTH) : EW'(modulus);
  assign m_dbl   = m_ext << 1;
  assign one_mod = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);

  // One multiplier bit per cycle, MSB first: acc = 2*acc + bit*mcand mod m.
  // Both acc and mcand stay at or below m, so the sum is below 3m.
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (mplr_r[WIDTH-1] ? EW'(mcand_r) : '0);
    if (sum >= m_dbl) begin
      acc_nxt = WIDTH'(sum - m_dbl);
    end else if (sum >= m_ext) begin
      acc_nxt = WIDTH'(sum - m_ext);
    end else begin
      acc_nxt = WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base;
      res_r  <= cmd.exp_zero ? WIDTH'(1) : one_mod;
    end
    if (cmd.start) begin
      acc_r <= '0;
      unique case (cmd.op)
        mexp_pkg::OP_RED: begin
          mplr_r  <= base_r;
          mcand_r <= WIDTH'(1);
        end
        mexp_pkg::OP_MUL: begin
          mplr_r  <= base_r;
          mcand_r <= res_r;
        end
        default: begin
          mplr_r  <= base_r;
          mcand_r <= base_r;
        end
      endcase
    end
    if (cmd.step) begin
      acc_r  <= acc_nxt;
      mplr_r <= mplr_r << 1;
    end
    if (cmd.commit) begin
      if (cmd.op == mexp_pkg::OP_MUL) begin
        res_r <= acc_nxt;
      end else begin
        base_r <= acc_nxt;
      end
    end
    if (cmd.emit) begin
      out_data_r <= res_r;
    end
  end

  assign out_data = out_data_r;

endmodule

@@ sv/mexp_ctrl.sv @@
// Controller: sequences reduction, multiply and square operations over the
// exponent bits and owns the request and result handshakes. Uses mexp_pkg.
module mexp_ctrl #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] exponent,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output mexp_pkg::cmd_t   cmd
);

  localparam int CW = $clog2(WIDTH);

  mexp_pkg::state_t state_r, state_nxt;
  mexp_pkg::op_t    op_r, op_nxt;
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] rest;

  assign rest = exp_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r  <= op_nxt;
    exp_r <= exp_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.exp_zero = (exponent == '0);
          exp_nxt      = exponent;
          op_nxt       = mexp_pkg::OP_RED;
          state_nxt    = (exponent == '0) ? mexp_pkg::ST_EMIT : mexp_pkg::ST_START;
        end
      end
      mexp_pkg::ST_START: begin
        cmd.start = 1'b1;
        cmd.op    = op_r;
        cnt_nxt   = '0;
        state_nxt = mexp_pkg::ST_STEP;
      end
      mexp_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        cmd.op   = op_r;
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CW'(WIDTH - 1)) begin
          cmd.commit = 1'b1;
          state_nxt  = mexp_pkg::ST_START;
          // The square after the last set exponent bit is never needed.
          unique case (op_r)
            mexp_pkg::OP_RED: begin
              op_nxt = exp_r[0] ? mexp_pkg::OP_MUL : mexp_pkg::OP_SQR;
            end
            mexp_pkg::OP_MUL: begin
              if (rest == '0) begin
                state_nxt = mexp_pkg::ST_EMIT;
              end else begin
                op_nxt = mexp_pkg::OP_SQR;
              end
            end
            default: begin
              exp_nxt = rest;
              op_nxt  = exp_r[1] ? mexp_pkg::OP_MUL : mexp_pkg::OP_SQR;
            end
          endcase
        end
      end
      mexp_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/modular_exponentiation_unit.sv @@
// Modular exponentiation, right-to-left square-and-multiply on one shared
// bit-serial modular multiplier. Each pass runs a start state and then the step
// states. Exponent zero skips the multiplier; else one reduction pass, a pass per
// set exponent bit and a pass per square below the highest set bit.
// One request at a time; the next is taken while the last result is held.
// Reset: modulus and exponent return to 1, no request or result is pending.
module modular_exponentiation_unit #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mexp_in_if.sink                        in_req,
  mexp_out_if.source                     out_res,
  input  logic                           cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]               cfg_wdata
);

  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] exponent_r;
  mexp_pkg::cmd_t   cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WIDTH'(1);
      exponent_r <= WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus_r  <= cfg_wdata;
        mexp_pkg::REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mexp_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .exponent  (exponent_r),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .cmd       (cmd)
  );

  mexp_datapath #(
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk      (clk),
    .modulus  (modulus_r),
    .in_base  (in_req.base_value),
    .cmd      (cmd),
    .out_data (out_res.power_result)
  );

endmodule
